@@ design/timed_event_sorted_queue_core_defines.svh @@
// Assertion macros shared by the timed event queue RTL.
`ifndef TIMED_EVENT_SORTED_QUEUE_CORE_DEFINES_SVH
`define TIMED_EVENT_SORTED_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TESQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TESQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/tesq_pkg.sv @@
// Types and constants of the timed event queue.
`timescale 1ns / 1ps
package tesq_pkg;

  localparam int unsigned EXPIRY_W    = 32;
  localparam int unsigned ID_W        = 16;
  localparam int unsigned OPCODE_W    = 3;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned NPOP_W      = 5;
  localparam int unsigned LEFT_W      = 5;

  localparam logic [OPCODE_W-1:0] OP_SCHED    = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_REMOVE   = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_POLL_ONE = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_POLL_ALL = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_CLEAR    = 3'd4;

  typedef enum logic [1:0] {
    KIND_SCHED   = 2'd0,
    KIND_REMOVE  = 2'd1,
    KIND_EXPIRED = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_INS_HEAD,
    ST_RM_RD,
    ST_RM_CMP,
    ST_SH_RD,
    ST_SH_WR,
    ST_POLL_RD,
    ST_POLL_CMP
  } st_t;

  typedef struct packed {
    logic [EXPIRY_W-1:0] expiry;
    logic [ID_W-1:0]     id;
  } entry_t;

endpackage

@@ design/timed_event_sorted_queue_core.sv @@
// Top level of the timed event queue: sequencer, control registers and result port.
`timescale 1ns / 1ps
// Usage overview.
// The block holds up to QUEUE_DEPTH pending events sorted by expiry time, with
// events of equal expiry kept in the order they were scheduled. A command
// transaction is taken at a rising edge where start is high and busy is low;
// in_opcode selects schedule, remove by id, poll one, poll all or clear.
// Every result transaction appears on the out_ ports for exactly one cycle,
// flagged by out_valid; the receiver cannot stall it, so nothing is held back.
// All work goes through one entry store with a registered read port, stepped
// by a small sequencer; each entry visited is first read, then compared and
// written. Results are registered, so a result shows up the cycle after the
// sequencer decides it.
// Clear, a command refused at the start and a schedule into an empty queue
// finish without the sequencer leaving idle. A schedule moves later entries
// toward the tail one by one. A remove searches from the head and, when the
// id is found, moves the entries behind it up. Each pop by a poll checks the
// head, then closes the gap. busy is high while the sequencer works on a
// command; a poll all emits one result per pop and marks the final one.
// Reset (synchronous, rst_n low) empties the queue and restarts id numbering;
// the store itself is not cleared, since only occupied slots are ever read.
`include "timed_event_sorted_queue_core_defines.svh"
module timed_event_sorted_queue_core import tesq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH  = 16,
  parameter int unsigned MAX_EVENT_ID = 65535
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [OPCODE_W-1:0] in_opcode,
  input  logic [30:0]         in_delay_ms,
  input  logic [ID_W-1:0]     in_target_id,
  input  logic [EXPIRY_W-1:0] in_now_ms,
  output logic                out_valid,
  output logic [1:0]          out_kind,
  output logic [ID_W-1:0]     out_event_id,
  output logic                out_ok,
  output logic                out_last_result,
  output logic [LEFT_W-1:0]   out_entries_left
);

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  // Sequencer and control state.
  st_t                 state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [ID_W-1:0]     last_id_r, last_id_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic [OPCODE_W-1:0] op_r, op_nxt;
  logic [NPOP_W-1:0]   npop_r, npop_nxt;

  // Operands held for the length of one command.
  logic [EXPIRY_W-1:0] key_r, key_nxt;
  logic [ID_W-1:0]     target_r, target_nxt;
  logic [ID_W-1:0]     hold_id_r, hold_id_nxt;

  // Result register.
  logic                out_valid_r, out_valid_nxt;
  kind_t               out_kind_r, out_kind_nxt;
  logic [ID_W-1:0]     out_id_r, out_id_nxt;
  logic                out_ok_r, out_ok_nxt;
  logic                out_last_r, out_last_nxt;
  logic [LEFT_W-1:0]   out_left_r, out_left_nxt;

  // Store port signals.
  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  entry_t              wr_data;
  logic [IW-1:0]       rd_addr;
  entry_t              rd_data;

  logic                accept;
  logic                q_full;
  logic                q_empty;
  logic [ID_W-1:0]     next_id;
  logic [EXPIRY_W-1:0] sched_expiry;
  logic                ins_later;
  logic                rm_hit;
  logic                rm_at_tail;
  logic                more_shift;
  logic                head_expired;
  logic                poll_all_more;
  logic [CW-1:0]       count_dec;

  tesq_mem #(
    .DEPTH (QUEUE_DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign q_full  = (count_r == CW'(QUEUE_DEPTH));
  assign q_empty = (count_r == '0);

  // Ids count up from 1 and wrap back to 1 after the highest allowed id.
  assign next_id = (last_id_r >= ID_W'(MAX_EVENT_ID)) ? ID_W'(1) : last_id_r + ID_W'(1);

  // Expiry wraps modulo 2^32.
  assign sched_expiry = in_now_ms + {1'b0, in_delay_ms};

  // The expiry comparisons serve insert and poll, the id comparison serves
  // remove; key_r holds either the new expiry (insert) or the current time (poll).
  assign ins_later     = (rd_data.expiry > key_r);
  assign head_expired  = (rd_data.expiry <= key_r);
  assign rm_hit        = (rd_data.id == target_r);
  assign count_dec     = count_r - CW'(1);
  assign rm_at_tail    = (CW'(idx_r) == count_dec);
  assign more_shift    = ((CW'(idx_r) + CW'(1)) < count_r);
  assign poll_all_more = (op_r == OP_POLL_ALL) && (npop_r != NPOP_W'(MAX_RESULTS))
                         && (count_dec != '0);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_opcode)
            OP_SCHED: begin
              if (!q_full && !q_empty) state_nxt = ST_INS_RD;
            end
            OP_REMOVE: begin
              if ((in_target_id != '0) && !q_empty) state_nxt = ST_RM_RD;
            end
            OP_POLL_ONE, OP_POLL_ALL: begin
              if (!q_empty) state_nxt = ST_POLL_RD;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_INS_RD:   state_nxt = ST_INS_CMP;
      ST_INS_CMP: begin
        if (ins_later) begin
          state_nxt = (idx_r == '0) ? ST_INS_HEAD : ST_INS_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_INS_HEAD: state_nxt = ST_IDLE;
      ST_RM_RD:    state_nxt = ST_RM_CMP;
      ST_RM_CMP: begin
        priority if (rm_hit) state_nxt = ST_SH_RD;
        else if (rm_at_tail) state_nxt = ST_IDLE;
        else state_nxt = ST_RM_RD;
      end
      ST_SH_RD: begin
        priority if (more_shift) state_nxt = ST_SH_WR;
        else if (poll_all_more) state_nxt = ST_POLL_RD;
        else state_nxt = ST_IDLE;
      end
      ST_SH_WR:    state_nxt = ST_SH_RD;
      ST_POLL_RD:  state_nxt = ST_POLL_CMP;
      ST_POLL_CMP: state_nxt = head_expired ? ST_SH_RD : ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, store accesses and results.
  always_comb begin
    count_nxt     = count_r;
    last_id_nxt   = last_id_r;
    idx_nxt       = idx_r;
    op_nxt        = op_r;
    npop_nxt      = npop_r;
    key_nxt       = key_r;
    target_nxt    = target_r;
    hold_id_nxt   = hold_id_r;
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    wr_data       = rd_data;
    rd_addr       = idx_r;
    out_valid_nxt = 1'b0;
    out_kind_nxt  = KIND_NONE;
    out_id_nxt    = '0;
    out_ok_nxt    = 1'b0;
    out_last_nxt  = 1'b1;
    out_left_nxt  = LEFT_W'(count_r);

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt     = in_opcode;
          target_nxt = in_target_id;
          npop_nxt   = '0;
          idx_nxt    = '0;
          key_nxt    = in_now_ms;
          unique case (in_opcode)
            OP_SCHED: begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_SCHED;
              if (!q_full) begin
                last_id_nxt = next_id;
                hold_id_nxt = next_id;
                key_nxt     = sched_expiry;
                if (q_empty) begin
                  // First entry goes straight to the head.
                  wr_en        = 1'b1;
                  wr_addr      = '0;
                  wr_data      = '{expiry: sched_expiry, id: next_id};
                  count_nxt    = CW'(1);
                  out_id_nxt   = next_id;
                  out_ok_nxt   = 1'b1;
                  out_left_nxt = LEFT_W'(1);
                end else begin
                  out_valid_nxt = 1'b0;
                  idx_nxt       = IW'(count_dec);
                end
              end
            end
            OP_REMOVE: begin
              if ((in_target_id == '0) || q_empty) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = KIND_REMOVE;
              end
            end
            OP_POLL_ONE, OP_POLL_ALL: begin
              if (q_empty) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = KIND_NONE;
              end
            end
            OP_CLEAR: begin
              count_nxt     = '0;
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_NONE;
              out_left_nxt  = '0;
            end
            default: out_valid_nxt = 1'b0;
          endcase
        end
      end
      ST_INS_RD: begin
        rd_addr = idx_r;
      end
      ST_INS_CMP: begin
        // Walk from the tail toward the head, moving later entries back one slot.
        wr_en   = 1'b1;
        wr_addr = idx_r + IW'(1);
        if (ins_later) begin
          wr_data = rd_data;
          if (idx_r != '0) idx_nxt = idx_r - IW'(1);
        end else begin
          wr_data       = '{expiry: key_r, id: hold_id_r};
          count_nxt     = count_r + CW'(1);
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_SCHED;
          out_id_nxt    = hold_id_r;
          out_ok_nxt    = 1'b1;
          out_left_nxt  = LEFT_W'(count_r + CW'(1));
        end
      end
      ST_INS_HEAD: begin
        wr_en         = 1'b1;
        wr_addr       = '0;
        wr_data       = '{expiry: key_r, id: hold_id_r};
        count_nxt     = count_r + CW'(1);
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_SCHED;
        out_id_nxt    = hold_id_r;
        out_ok_nxt    = 1'b1;
        out_left_nxt  = LEFT_W'(count_r + CW'(1));
      end
      ST_RM_RD: begin
        rd_addr = idx_r;
      end
      ST_RM_CMP: begin
        priority if (rm_hit) begin
          idx_nxt = idx_r;
        end else if (rm_at_tail) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_REMOVE;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      ST_SH_RD: begin
        if (more_shift) begin
          rd_addr = idx_r + IW'(1);
        end else begin
          // Gap closed: the slot count drops and, unless a poll all pops on, the result goes out.
          count_nxt     = count_dec;
          out_left_nxt  = LEFT_W'(count_dec);
          idx_nxt       = '0;
          if (op_r == OP_REMOVE) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_REMOVE;
            out_id_nxt    = target_r;
            out_ok_nxt    = 1'b1;
          end else if (!poll_all_more) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_EXPIRED;
            out_id_nxt    = hold_id_r;
          end
        end
      end
      ST_SH_WR: begin
        wr_en   = 1'b1;
        wr_addr = idx_r;
        wr_data = rd_data;
        idx_nxt = idx_r + IW'(1);
      end
      ST_POLL_RD: begin
        rd_addr = '0;
      end
      ST_POLL_CMP: begin
        if (head_expired) begin
          // A pop before this one is now known not to be the final result.
          if (npop_r != '0) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_EXPIRED;
            out_id_nxt    = hold_id_r;
            out_last_nxt  = 1'b0;
          end
          hold_id_nxt = rd_data.id;
          npop_nxt    = npop_r + NPOP_W'(1);
          idx_nxt     = '0;
        end else begin
          out_valid_nxt = 1'b1;
          if (npop_r != '0) begin
            out_kind_nxt = KIND_EXPIRED;
            out_id_nxt   = hold_id_r;
          end else begin
            out_kind_nxt = KIND_NONE;
          end
        end
      end
      default: out_valid_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      last_id_r   <= '0;
      idx_r       <= '0;
      op_r        <= OP_SCHED;
      npop_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      last_id_r   <= last_id_nxt;
      idx_r       <= idx_nxt;
      op_r        <= op_nxt;
      npop_r      <= npop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    target_r   <= target_nxt;
    hold_id_r  <= hold_id_nxt;
    out_kind_r <= out_kind_nxt;
    out_id_r   <= out_id_nxt;
    out_ok_r   <= out_ok_nxt;
    out_last_r <= out_last_nxt;
    out_left_r <= out_left_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_event_id     = out_id_r;
  assign out_ok           = out_ok_r;
  assign out_last_result  = out_last_r;
  assign out_entries_left = out_left_r;

  // Occupancy never goes past the store depth.
  `TESQ_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(QUEUE_DEPTH), "occupancy over depth")
  // The final result of a command coincides with the sequencer being back at rest.
  `TESQ_ASSERT_NOW(a_last_idle, out_valid && out_last_result, !busy, "final result while busy")
  // Only schedule and remove replies can report success, and never with id zero.
  `TESQ_ASSERT_NOW(a_ok_kind, out_valid && out_ok,
    ((out_kind == KIND_SCHED) || (out_kind == KIND_REMOVE)) && (out_event_id != '0),
    "success flag on wrong result")
  // A clear empties the queue on the next cycle.
  `TESQ_ASSERT_NEXT(a_clear_empty, accept && (in_opcode == OP_CLEAR), count_r == '0,
    "clear left entries")

endmodule

@@ design/tesq_mem.sv @@
// Entry store of the timed event queue: one write port, one registered read port.
`timescale 1ns / 1ps
module tesq_mem import tesq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  entry_t                   wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output entry_t                   rd_data
);

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ tb/sv/timed_event_sorted_queue_core_tb.sv @@
// Self-checking testbench for the timed event queue core.
`timescale 1ns / 1ps
// The testbench drives command transactions into the queue and checks every result
// transaction against an internal prediction of the queue contents.
//
// Prediction: a small scoreboard class keeps its own sorted copy of the pending
// events (expiry time and id per slot), the occupancy and the last id handed out.
// Each accepted command transaction is applied to that copy and the results it
// must cause are appended to a FIFO of awaited replies. Every result transaction
// seen on the out_ ports is compared field by field with the oldest awaited reply.
//
// Stimulus runs in two phases:
//   1. A directed pass: polls and removes on an empty queue, remove of id zero
//      and of an absent id, expiry arithmetic that wraps past 2^32, two events
//      with the same expiry, the unused opcodes, a remove of a present id, the
//      boundary where expiry equals the current time, clear on a non-empty
//      queue, a full queue with a rejected schedule, and a poll all that pops
//      every one of the sixteen entries at once.
//   2. A random pass of mostly well-formed traffic: a slowly advancing time base
//      with occasional jumps anywhere in the 32-bit range, short delays mixed
//      with full-range ones, removes that mostly name live ids, and some noise.
//
// The sender idles at random, except through a long calm stretch, and now and
// then waits until every awaited reply has arrived before it goes on. The
// receiver side cannot stall, so results are simply sampled.
// A watchdog ends the run when nothing is accepted on either side for too long.
module timed_event_sorted_queue_core_tb;
  import tesq_pkg::*;

  localparam int unsigned QUEUE_DEPTH  = 16;
  localparam int unsigned MAX_EVENT_ID = 65535;
  localparam int unsigned RANDOM_ITEMS = 400;
  // The limit lies far beyond the longest quiet gap a legal command can cause,
  // such as a pop in a poll all that closes a gap of up to fifteen entries.
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 64;

  // Scoreboard: mirrors the queue and holds the replies still to come.
  class tesq_scoreboard;
    typedef struct packed {
      kind_t             kind;
      logic [ID_W-1:0]   event_id;
      logic              ok;
      logic              last_result;
      logic [LEFT_W-1:0] left;
    } reply_t;

    logic [EXPIRY_W-1:0] expiry_at[QUEUE_DEPTH];
    logic [ID_W-1:0]     id_at[QUEUE_DEPTH];
    int unsigned         depth;
    logic [ID_W-1:0]     last_id;
    reply_t              awaiting[$];
    int unsigned         mismatches;

    function new();
      depth      = 0;
      last_id    = '0;
      mismatches = 0;
    endfunction

    // The occupancy reported is the one after the state change for this reply.
    function void add_reply(kind_t kind, logic [ID_W-1:0] event_id, logic ok, logic last_result);
      reply_t r;
      r.kind        = kind;
      r.event_id    = event_id;
      r.ok          = ok;
      r.last_result = last_result;
      r.left        = LEFT_W'(depth);
      awaiting.push_back(r);
    endfunction

    function void drop_entry(int unsigned pos);
      for (int unsigned i = pos; i + 1 < depth; i++) begin
        expiry_at[i] = expiry_at[i + 1];
        id_at[i]     = id_at[i + 1];
      end
      depth--;
    endfunction

    function bit head_due(logic [EXPIRY_W-1:0] now);
      return depth > 0 && expiry_at[0] <= now;
    endfunction

    function void note_command(logic [OPCODE_W-1:0] opcode, logic [30:0] delay,
                               logic [ID_W-1:0] target, logic [EXPIRY_W-1:0] now);
      logic [EXPIRY_W-1:0] due;
      logic [ID_W-1:0]     id;
      int unsigned         pos;
      int unsigned         pops;
      bit                  found;
      case (opcode)
        OP_SCHED: begin
          if (depth >= QUEUE_DEPTH) begin
            add_reply(KIND_SCHED, '0, 1'b0, 1'b1);
          end else begin
            if (last_id >= ID_W'(MAX_EVENT_ID)) id = ID_W'(1);
            else id = last_id + 1'b1;
            last_id = id;
            due = now + EXPIRY_W'(delay);
            // Equal expiry times keep schedule order: go behind them.
            pos = 0;
            while (pos < depth && expiry_at[pos] <= due) pos++;
            for (int unsigned i = depth; i > pos; i--) begin
              expiry_at[i] = expiry_at[i - 1];
              id_at[i]     = id_at[i - 1];
            end
            expiry_at[pos] = due;
            id_at[pos]     = id;
            depth++;
            add_reply(KIND_SCHED, id, 1'b1, 1'b1);
          end
        end
        OP_REMOVE: begin
          found = 1'b0;
          if (target != '0) begin
            for (pos = 0; pos < depth && !found; pos++) begin
              if (id_at[pos] == target) begin
                drop_entry(pos);
                found = 1'b1;
              end
            end
          end
          if (found) add_reply(KIND_REMOVE, target, 1'b1, 1'b1);
          else add_reply(KIND_REMOVE, '0, 1'b0, 1'b1);
        end
        OP_POLL_ONE: begin
          if (head_due(now)) begin
            id = id_at[0];
            drop_entry(0);
            add_reply(KIND_EXPIRED, id, 1'b0, 1'b1);
          end else begin
            add_reply(KIND_NONE, '0, 1'b0, 1'b1);
          end
        end
        OP_POLL_ALL: begin
          pops = 0;
          if (!head_due(now)) add_reply(KIND_NONE, '0, 1'b0, 1'b1);
          while (pops < MAX_RESULTS && head_due(now)) begin
            id = id_at[0];
            drop_entry(0);
            pops++;
            add_reply(KIND_EXPIRED, id, 1'b0, !(pops < MAX_RESULTS && head_due(now)));
          end
        end
        OP_CLEAR: begin
          depth = 0;
          add_reply(KIND_NONE, '0, 1'b0, 1'b1);
        end
        default: ;  // Unused opcodes cause nothing.
      endcase
    endfunction

    function void check_reply(logic [1:0] kind, logic [ID_W-1:0] event_id, logic ok,
                              logic last_result, logic [LEFT_W-1:0] left);
      reply_t want;
      if (awaiting.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result kind %0d id %0d ok %0b last %0b left %0d",
                   $time, kind, event_id, ok, last_result, left);
        return;
      end
      want = awaiting.pop_front();
      if (kind !== want.kind || event_id !== want.event_id || ok !== want.ok ||
          last_result !== want.last_result || left !== want.left) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch: expected kind %0d id %0d ok %0b last %0b left %0d,",
                   $time, want.kind, want.event_id, want.ok, want.last_result, want.left);
          $display("  got kind %0d id %0d ok %0b last %0b left %0d",
                   kind, event_id, ok, last_result, left);
        end
      end
    endfunction

    function void flag_missing();
      if (awaiting.size() != 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: %0d expected results never arrived", $time, awaiting.size());
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [OPCODE_W-1:0] in_opcode;
  logic [30:0]         in_delay_ms;
  logic [ID_W-1:0]     in_target_id;
  logic [EXPIRY_W-1:0] in_now_ms;
  logic                out_valid;
  logic [1:0]          out_kind;
  logic [ID_W-1:0]     out_event_id;
  logic                out_ok;
  logic                out_last_result;
  logic [LEFT_W-1:0]   out_entries_left;

  tesq_scoreboard sb;
  int unsigned    quiet_cycles;

  timed_event_sorted_queue_core #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_EVENT_ID(MAX_EVENT_ID)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_delay_ms     (in_delay_ms),
    .in_target_id    (in_target_id),
    .in_now_ms       (in_now_ms),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_event_id    (out_event_id),
    .out_ok          (out_ok),
    .out_last_result (out_last_result),
    .out_entries_left(out_entries_left)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // One process both records accepted commands and checks results, so that the
  // order of the two is fixed. Results are registered, so a command never has its
  // result at the edge that accepts it, and noting first is safe.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_command(in_opcode, in_delay_ms, in_target_id, in_now_ms);
      if (out_valid)
        sb.check_reply(out_kind, out_event_id, out_ok, out_last_result, out_entries_left);
    end
  end

  // Watchdog: any accepted transaction on either side resets the count.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Presents one command at the falling edge and returns after the rising edge
  // that accepts it. start stays high, so back-to-back commands need no gap.
  task automatic issue_command(logic [OPCODE_W-1:0] opcode, logic [30:0] delay,
                               logic [ID_W-1:0] target, logic [EXPIRY_W-1:0] now);
    @(negedge clk);
    start        <= 1'b1;
    in_opcode    <= opcode;
    in_delay_ms  <= delay;
    in_target_id <= target;
    in_now_ms    <= now;
    do @(posedge clk); while (busy);
  endtask

  task automatic skip_cycle();
    @(negedge clk);
    start <= 1'b0;
  endtask

  // Sender holds off until every awaited result transaction has been seen.
  task automatic wait_for_replies();
    skip_cycle();
    while (sb.awaiting.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [EXPIRY_W-1:0] time_base;
    logic [OPCODE_W-1:0] opcode;
    logic [30:0]         delay;
    logic [ID_W-1:0]     target;
    int unsigned         count;
    int unsigned         pick;
    bit                  calm;

    sb           = new();
    rst_n        = 1'b0;
    start        = 1'b0;
    in_opcode    = OP_SCHED;
    in_delay_ms  = '0;
    in_target_id = '0;
    in_now_ms    = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed pass. Ids are handed out from 1 after reset.
    issue_command(OP_POLL_ONE, '0, '0, '0);              // empty: nothing expired
    issue_command(OP_POLL_ALL, '0, '0, '1);              // empty even at the latest time
    issue_command(OP_REMOVE, '0, '0, '0);                // id zero is refused
    issue_command(OP_REMOVE, '1, '1, '1);                // id not present
    issue_command(OP_SCHED, '0, '0, '0);                 // id 1, expires at 0
    issue_command(OP_SCHED, '1, '0, '1);                 // id 2, expiry wraps past 2^32
    issue_command(OP_SCHED, '0, '0, '0);                 // id 3, ties with id 1, goes behind
    for (int op = OP_CLEAR + 1; op < (1 << OPCODE_W); op++)
      issue_command(OPCODE_W'(op), '1, '1, '1);          // unused opcodes do nothing
    issue_command(OP_REMOVE, '0, ID_W'(3), '0);
    issue_command(OP_POLL_ONE, '0, '0, '0);              // pops id 1
    issue_command(OP_POLL_ALL, '0, '0, 32'h7FFF_FFFD);   // one short of id 2's expiry
    issue_command(OP_CLEAR, '0, '0, '0);                 // clears with id 2 still pending
    // Fill the queue with shrinking delays so that each schedule but the last
    // lands at the head; the last two share an expiry. Then one schedule too many.
    for (int i = 0; i < QUEUE_DEPTH; i++)
      issue_command(OP_SCHED, 31'(i < QUEUE_DEPTH - 1 ? QUEUE_DEPTH - 1 - i : 1), '0,
                    32'd100);
    issue_command(OP_SCHED, '0, '0, '0);                 // rejected, no id consumed
    issue_command(OP_POLL_ALL, '0, '0, 32'd115);         // latest expiry equals now: all pop
    wait_for_replies();

    // Random pass. Unused opcodes are sent as noise but do not count.
    time_base = $urandom();
    count     = 0;
    while (count < RANDOM_ITEMS) begin
      calm = (count >= 180 && count < 290);
      if (count == 120 || count == 350) wait_for_replies();
      if (!calm)
        while ($urandom_range(99) < 22) skip_cycle();

      if ($urandom_range(99) < 90) time_base = time_base + $urandom_range(8);
      else time_base = $urandom();

      delay  = 31'($urandom());
      target = ID_W'($urandom());
      pick   = $urandom_range(99);
      if (pick < 40) begin
        opcode = OP_SCHED;
        if ($urandom_range(99) < 75) delay = 31'($urandom_range(40));
      end else if (pick < 58) begin
        opcode = OP_REMOVE;
        pick   = $urandom_range(99);
        if (pick < 65 && sb.depth > 0) target = sb.id_at[$urandom_range(sb.depth - 1)];
        else if (pick < 80) target = '0;
      end else if (pick < 72) begin
        opcode = OP_POLL_ONE;
      end else if (pick < 86) begin
        opcode = OP_POLL_ALL;
      end else if (pick < 91) begin
        opcode = OP_CLEAR;
      end else begin
        opcode = OPCODE_W'($urandom_range((1 << OPCODE_W) - 1, OP_CLEAR + 1));
      end

      issue_command(opcode, delay, target, time_base);
      if (opcode <= OP_CLEAR) count++;
    end

    // Let the last results drain, then watch a little longer for strays.
    wait_for_replies();
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.flag_missing();
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
